// ===== design/sq8_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sq8_pkg
// Shared types and constants of the per-dimension SQ8 quantizer.
// ---------------------------------------------------------------------------
package sq8_pkg;

  localparam int DIM_MAX     = 1024;
  localparam int IDX_W       = $clog2(DIM_MAX);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  // back-end pipeline registers ahead of the output register
  localparam int STAGES      = 10;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_DECODE = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic {
    KIND_ENC = 1'b0,
    KIND_DEC = 1'b1
  } kind_t;

  // item handed from the front end to the back end
  typedef struct packed {
    kind_t              kind;
    logic [7:0]         code;
    logic signed [31:0] sample;
    logic signed [31:0] lb;
    logic [30:0]        rng;
  } work_t;

  // one back-end pipeline register
  typedef struct packed {
    logic               vld;
    kind_t              kind;
    logic signed [31:0] lb;
    logic [30:0]        d;
    logic signed [32:0] t;
    logic [39:0]        rem;
    logic [31:0]        q;
    logic               zero;
    logic               full;
  } stage_t;

endpackage

// ===== design/sq8_item_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sq8_item_if / sq8_result_if
// Valid/ready channels carrying quantizer items and results.
// ---------------------------------------------------------------------------
interface sq8_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [9:0]         dim_index;
  logic signed [31:0] sample_value;
  logic [7:0]         code_in;
  logic signed [31:0] lower_bound_in;
  logic [30:0]        range_in;

  modport source (output valid, opcode, dim_index, sample_value, code_in,
                  lower_bound_in, range_in, input ready);
  modport sink (input valid, opcode, dim_index, sample_value, code_in,
                lower_bound_in, range_in, output ready);
endinterface

interface sq8_result_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [7:0]         code_out;
  logic signed [31:0] value_out;

  modport source (output valid, result_kind, code_out, value_out, input ready);
  modport sink (input valid, result_kind, code_out, value_out, output ready);
endinterface

// ===== design/sq8_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sq8_front
// Accepts items, writes table loads, looks up table entries for encode and
// decode items and hands them on.
// ---------------------------------------------------------------------------
module sq8_front (
  input  logic               clk,
  input  logic               rst,
  sq8_item_if.sink           items,
  output logic               push_valid,
  output sq8_pkg::work_t     push_data,
  input  logic               push_ready
);
  import sq8_pkg::*;

  logic [31:0]        lb_mem  [DIM_MAX];
  logic [30:0]        rng_mem [DIM_MAX];
  logic [31:0]        lb_rd;
  logic [30:0]        rng_rd;
  logic               f_vld;
  kind_t              f_kind;
  logic [7:0]         f_code;
  logic signed [31:0] f_sample;
  logic               accept;
  opcode_t            op;

  assign op          = opcode_t'(items.opcode);
  assign items.ready = !f_vld || push_ready;
  assign accept      = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (accept && op == OP_LOAD) begin
      lb_mem[items.dim_index[IDX_W-1:0]]  <= items.lower_bound_in;
      rng_mem[items.dim_index[IDX_W-1:0]] <= items.range_in;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lb_rd    <= lb_mem[items.dim_index[IDX_W-1:0]];
      rng_rd   <= rng_mem[items.dim_index[IDX_W-1:0]];
      f_kind   <= (op == OP_DECODE) ? KIND_DEC : KIND_ENC;
      f_code   <= items.code_in;
      f_sample <= items.sample_value;
    end
  end

  // loads and the unused opcode leave no work behind
  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (accept) begin
      f_vld <= (op == OP_ENCODE) || (op == OP_DECODE);
    end else if (push_ready) begin
      f_vld <= 1'b0;
    end
  end

  assign push_valid = f_vld;
  always_comb begin
    push_data        = '0;
    push_data.kind   = f_kind;
    push_data.code   = f_code;
    push_data.sample = f_sample;
    push_data.lb     = lb_rd;
    push_data.rng    = rng_rd;
  end

endmodule

// ===== design/sq8_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sq8_queue
// Short FIFO between the front end and the arithmetic back end.
// ---------------------------------------------------------------------------
module sq8_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  sq8_pkg::work_t push_data,
  output logic           push_ready,
  output logic           pop_valid,
  output sq8_pkg::work_t pop_data,
  input  logic           pop_ready
);
  import sq8_pkg::*;

  work_t             q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 1'b1)
    else $error("queue count missed a pop");

endmodule

// ===== design/sq8_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sq8_back
// Arithmetic pipeline: encode by one quotient bit per stage, decode by a
// reciprocal divide by 255 with correction, then the output register.
// ---------------------------------------------------------------------------
module sq8_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  input  sq8_pkg::work_t pop_data,
  output logic           pop_ready,
  sq8_result_if.source   results
);
  import sq8_pkg::*;

  stage_t             p [1:STAGES];
  logic               en;
  logic               out_vld;
  logic               out_kind;
  logic [7:0]         out_code;
  logic signed [31:0] out_value;
  logic signed [33:0] dec_sum;
  logic [STAGES-1:0]  stage_vld;

  function automatic stage_t step(input int k, input stage_t s);
    stage_t      o;
    logic [31:0] tu;
    logic [39:0] dsh;
    logic [10:0] r;
    int          b;
    o  = s;
    tu = s.t[31:0];
    b  = 9 - k;
    if (s.kind == KIND_ENC) begin
      if (k == 1) begin
        o.zero = (s.d == '0) || s.t[32] || (s.t == '0);
        o.full = (43'(tu) * 43'd1000) > (43'(s.d) * 43'd999);
        o.rem  = 40'(tu) * 40'd255;
        o.q    = '0;
      end else begin
        // one quotient bit per stage, most significant first
        dsh = 40'(s.d) << b;
        if (s.rem >= dsh) begin
          o.rem  = s.rem - dsh;
          o.q[b] = 1'b1;
        end
      end
    end else begin
      case (k)
        1: o.q = 32'(s.rem >> 8) + 32'(s.rem >> 16) + 32'(s.rem >> 24)
               + 32'(s.rem >> 32);
        2: o.rem = s.rem - 40'(s.q) * 40'd255;
        3: begin
          // estimate is short by at most four
          r   = s.rem[10:0];
          o.q = s.q + 32'(r >= 11'd255) + 32'(r >= 11'd510)
              + 32'(r >= 11'd765) + 32'(r >= 11'd1020);
        end
        default: o = s;
      endcase
    end
    return o;
  endfunction

  assign en        = !out_vld || results.ready;
  assign pop_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= STAGES; k++) begin
        p[k].vld <= 1'b0;
      end
    end else if (en) begin
      p[1].vld  <= pop_valid;
      p[1].kind <= pop_data.kind;
      p[1].lb   <= pop_data.lb;
      p[1].d    <= pop_data.rng;
      p[1].t    <= 33'(pop_data.sample) - 33'(pop_data.lb);
      p[1].rem  <= 40'(pop_data.code) * 40'(pop_data.rng);
      p[1].q    <= '0;
      p[1].zero <= 1'b0;
      p[1].full <= 1'b0;
      for (int k = 1; k < STAGES; k++) begin
        p[k+1] <= step(k, p[k]);
      end
    end
  end

  assign dec_sum = 34'(p[STAGES].lb) + 34'(p[STAGES].q);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= p[STAGES].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_kind <= p[STAGES].kind;
      if (p[STAGES].kind == KIND_ENC) begin
        out_value <= '0;
        if (p[STAGES].zero) begin
          out_code <= 8'd0;
        end else if (p[STAGES].full) begin
          out_code <= 8'd255;
        end else begin
          out_code <= p[STAGES].q[7:0];
        end
      end else begin
        out_code <= 8'd0;
        if (!dec_sum[33] && dec_sum[32:31] != 2'b00) begin
          out_value <= 32'sh7FFF_FFFF;
        end else begin
          out_value <= dec_sum[31:0];
        end
      end
    end
  end

  assign results.valid       = out_vld;
  assign results.result_kind = out_kind;
  assign results.code_out    = out_code;
  assign results.value_out   = out_value;

  always_comb begin
    for (int k = 1; k <= STAGES; k++) begin
      stage_vld[k-1] = p[k].vld;
    end
  end

  a_enc_no_value: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_kind == KIND_ENC) |-> out_value == '0)
    else $error("encode result carries a value");
  a_dec_no_code: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_kind == KIND_DEC) |-> out_code == '0)
    else $error("decode result carries a code");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(stage_vld))
    else $error("pipeline moved while stalled");

endmodule

// ===== design/per_dimension_sq8_quantizer_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// per_dimension_sq8_quantizer_core
// Path from item accept to result valid: table read, queue,
//   ten arithmetic stages, output register; loads give no result.
// The one-bit-per-stage divider takes one item per cycle unless the result channel stalls.
// Reset clears control state only; table entries are undefined until loaded.
// ---------------------------------------------------------------------------
module per_dimension_sq8_quantizer_core (
  input  logic         clk,
  input  logic         rst,
  sq8_item_if.sink     items,
  sq8_result_if.source results
);
  import sq8_pkg::*;

  logic  push_valid;
  logic  push_ready;
  work_t push_data;
  logic  pop_valid;
  logic  pop_ready;
  work_t pop_data;

  sq8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  sq8_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  sq8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .results   (results)
  );

endmodule

// ===== sim/per_dimension_sq8_quantizer_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// per_dimension_sq8_quantizer_core_tb
// Loads per-dimension bound/range entries, then drives encode, decode and
// unused-opcode items. Each result is checked against a local Q16.16 quantizer model.
// Both channels stall in random bursts, except near the end of the run.
// ---------------------------------------------------------------------------
module per_dimension_sq8_quantizer_core_tb;
  import sq8_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 1550;
  localparam int QUIET_TAIL     = 300;

  typedef struct {
    kind_t              kind;
    logic [7:0]         code;
    logic signed [31:0] value;
  } quant_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sq8_item_if   items ();
  sq8_result_if results ();

  per_dimension_sq8_quantizer_core uut (
    .clk(clk),
    .rst(rst),
    .items(items),
    .results(results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the dimension table
  logic signed [31:0] lb_table [DIM_MAX];
  logic [30:0]        rng_table [DIM_MAX];
  bit                 loaded [DIM_MAX];
  int unsigned        loaded_dims [$];

  quant_result_t expected_results [$];
  int  error_count = 0;
  bit  quiet = 1'b0;
  int  stall_left = 0;
  int  idle_cycles = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Applies one item to the local table and returns its expected result.
  function automatic bit quantize_predict(input opcode_t op, input int unsigned idx,
                                          input logic signed [31:0] sample,
                                          input logic [7:0] code,
                                          input logic signed [31:0] lb_in,
                                          input logic [30:0] rng_in,
                                          output quant_result_t r);
    longint lb;
    longint rng;
    longint t;
    longint v;
    r = '{KIND_ENC, 8'd0, 32'sd0};
    if (op == OP_LOAD) begin
      lb_table[idx]  = lb_in;
      rng_table[idx] = rng_in;
      if (!loaded[idx]) begin
        loaded[idx] = 1'b1;
        loaded_dims.push_back(idx);
      end
      return 1'b0;
    end
    if (op == OP_NONE) return 1'b0;
    lb  = longint'(lb_table[idx]);
    rng = longint'(rng_table[idx]);
    if (op == OP_ENCODE) begin
      if (rng != 0) begin
        t = longint'(sample) - lb;
        if (t > 0) begin
          if (t * 1000 > rng * 999) r.code = 8'd255;
          else r.code = 8'(t * 255 / rng);
        end
      end
    end else begin
      r.kind = KIND_DEC;
      v = lb + (longint'(code) * rng) / 255;
      if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
      if (v < -64'sh80000000) v = -64'sh80000000;
      r.value = 32'(v);
    end
    return 1'b1;
  endfunction

  // valid stays up after an item; a random gap in the next call or the drain lowers it
  task automatic send_item(input opcode_t op, input int unsigned idx,
                           input logic signed [31:0] sample, input logic [7:0] code,
                           input logic signed [31:0] lb_in, input logic [30:0] rng_in);
    quant_result_t r;
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      items.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    items.valid          <= 1'b1;
    items.opcode         <= op;
    items.dim_index      <= idx[9:0];
    items.sample_value   <= sample;
    items.code_in        <= code;
    items.lower_bound_in <= lb_in;
    items.range_in       <= rng_in;
    do @(posedge clk); while (!items.ready);
    if (quantize_predict(op, idx, sample, code, lb_in, rng_in, r))
      expected_results.push_back(r);
    @(negedge clk);
  endtask

  // result ready: random stall bursts, always ready near the end
  always @(negedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else if (quiet) begin
      results.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      results.ready <= 1'b0;
    end else if ($urandom_range(0, 6) == 0) begin
      stall_left    <= $urandom_range(0, 6);
      results.ready <= 1'b0;
    end else begin
      results.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    quant_result_t w;
    if (!rst && results.valid && results.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result count", 1, 0);
      end else begin
        w = expected_results.pop_front();
        if (results.result_kind !== w.kind)
          report_mismatch("result_kind", results.result_kind, w.kind);
        if (results.code_out !== w.code)
          report_mismatch("code_out", results.code_out, w.code);
        if (results.value_out !== w.value)
          report_mismatch("value_out", results.value_out, w.value);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (items.valid && items.ready) || (results.valid && results.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    items.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_item(OP_LOAD, 0, 0, 0, 32'sh0, 31'h7FFFFFFF);
    send_item(OP_LOAD, 1023, 0, 0, -32'sh80000000, 31'h7FFFFFFF);
    send_item(OP_LOAD, 5, 0, 0, 32'sh7FFFFFFF, 31'h7FFFFFFF);
    send_item(OP_LOAD, 6, 0, 0, 32'sh10000, 31'd0);
    send_item(OP_LOAD, 7, 0, 0, 32'sh0, 31'd1000);
    // zero range
    send_item(OP_ENCODE, 6, 32'sh7FFFFFFF, 0, 0, 0);
    send_item(OP_DECODE, 6, 0, 8'd255, 0, 0);
    // negative t, full span, sample extremes
    send_item(OP_ENCODE, 0, -32'sh80000000, 0, 0, 0);
    send_item(OP_ENCODE, 0, 32'sh7FFFFFFF, 0, 0, 0);
    send_item(OP_ENCODE, 1023, 32'sh7FFFFFFF, 0, 0, 0);
    send_item(OP_ENCODE, 1023, -32'sh80000000, 0, 0, 0);
    // 999/1000 threshold
    send_item(OP_ENCODE, 7, 32'sd999, 0, 0, 0);
    send_item(OP_ENCODE, 7, 32'sd1000, 0, 0, 0);
    send_item(OP_ENCODE, 7, 32'sd998, 0, 0, 0);
    send_item(OP_ENCODE, 7, 32'sd1, 0, 0, 0);
    // decode saturation at the top, and the lowest value
    send_item(OP_DECODE, 5, 0, 8'd255, 0, 0);
    send_item(OP_DECODE, 1023, 0, 8'd0, 0, 0);
    send_item(OP_DECODE, 1023, 0, 8'd255, 0, 0);
    send_item(OP_DECODE, 0, 0, 8'd128, 0, 0);
    // unused opcode is dropped
    send_item(OP_NONE, 1023, -1, 8'hFF, -1, 31'h7FFFFFFF);
    send_item(OP_DECODE, 7, 0, 8'd1, 0, 0);
  endtask

  task automatic test_drain_pause();
    wait_drained();
    send_item(OP_ENCODE, 7, 32'sd500, 0, 0, 0);
  endtask

  task automatic test_random();
    int unsigned idx;
    int          sel;
    longint      s;
    logic [30:0] rng;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
        case ($urandom_range(0, 3))
          0: rng = 31'($urandom_range(0, 300));
          1: rng = 31'($urandom);
          2: rng = 31'h7FFFFFFF;
          default: rng = 31'($urandom_range(0, 32'h000FFFFF));
        endcase
        send_item(OP_LOAD, idx, 32'($urandom), 8'($urandom), 32'($urandom), rng);
      end else if (sel < 30) begin
        send_item(OP_NONE, $urandom_range(0, 1023), 32'($urandom), 8'($urandom),
                  32'($urandom), 31'($urandom));
        n--;
      end else begin
        idx = loaded_dims[$urandom_range(0, loaded_dims.size() - 1)];
        if (sel < 65) begin
          if ($urandom_range(0, 3) == 0) s = longint'(signed'(32'($urandom)));
          else s = longint'(lb_table[idx]) - 3 +
                   longint'($urandom_range(0, 32'(rng_table[idx]) + 6));
          send_item(OP_ENCODE, idx, 32'(s), 8'($urandom), 32'($urandom), 31'($urandom));
        end else begin
          send_item(OP_DECODE, idx, 32'($urandom), 8'($urandom), 32'($urandom),
                    31'($urandom));
        end
      end
    end
  endtask

  initial begin
    items.valid          = 1'b0;
    items.opcode         = OP_NONE;
    items.dim_index      = '0;
    items.sample_value   = '0;
    items.code_in        = '0;
    items.lower_bound_in = '0;
    items.range_in       = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_drain_pause();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
